[sv/spcr_pkg.sv]
// Shared types and constants for the step pad coverage resolver.
// Depends on nothing; every other file of the block imports it.
`timescale 1ns / 1ps

package spcr_pkg;

  // Field widths fixed by the item format
  localparam int StepW = 4;
  localparam int GateW = 8;
  localparam int MixW  = 8;
  localparam int LenW  = 5;

  // Default row size
  localparam int StepCountDef = 16;

  // Item kinds
  typedef enum logic {
    KindWrite = 1'b0,
    KindQuery = 1'b1
  } kind_e;

  // Write broadcast to every cell
  typedef struct packed {
    logic             en;
    logic [StepW-1:0] step;
    logic [GateW-1:0] gate;
    logic [MixW-1:0]  mix;
    logic [LenW-1:0]  len;
  } wr_t;

  // Search record handed from cell to cell
  typedef struct packed {
    logic             vld;
    logic [StepW-1:0] step;
    logic             found;
    logic [StepW-1:0] start;
    logic [LenW-1:0]  len;
    logic [MixW-1:0]  mix;
  } rec_t;

  // One result item
  typedef struct packed {
    logic             covered;
    logic [StepW-1:0] start;
    logic [StepW-1:0] offset;
    logic [LenW-1:0]  len;
    logic [MixW-1:0]  mix;
  } res_t;

endpackage

[sv/spcr_cell.sv]
// One step pad cell: holds a pad and passes the search record to its neighbor.
// Depends on spcr_pkg.
`timescale 1ns / 1ps

module spcr_cell #(
  parameter int CellIdx = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  spcr_pkg::wr_t  wr_i,
  input  spcr_pkg::rec_t rec_i,
  output spcr_pkg::rec_t rec_o
);
  import spcr_pkg::*;

  logic [GateW-1:0] gate_q;
  logic [MixW-1:0]  mix_q;
  logic [LenW-1:0]  len_q;
  rec_t             rec_d, rec_q;
  logic             active;
  logic             in_reach;

  // Store the pad when the write names this cell
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gate_q <= '0;
      mix_q  <= '0;
      len_q  <= LenW'(1);
    end else if (wr_i.en && (int'(wr_i.step) == CellIdx)) begin
      gate_q <= wr_i.gate;
      mix_q  <= wr_i.mix;
      len_q  <= wr_i.len;
    end
  end

  // Take over the record when this pad is active and not past the queried step;
  // later cells are nearer to the step, so the last match wins
  assign active   = (gate_q != '0) && (mix_q != '0);
  assign in_reach = (CellIdx <= int'(rec_i.step));

  always_comb begin
    rec_d = rec_i;
    if (rec_i.vld && active && in_reach) begin
      rec_d.found = 1'b1;
      rec_d.start = StepW'(CellIdx);
      rec_d.len   = len_q;
      rec_d.mix   = mix_q;
    end
  end

  // Advance the record one cell per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rec_q <= '0;
    end else begin
      rec_q <= rec_d;
    end
  end

  assign rec_o = rec_q;

endmodule

[sv/step_pad_coverage_resolver.sv]
// Step pad coverage resolver: a write updates the addressed cell; a query runs
// through the row of StepCount cells, one cell per cycle, and its result is
// then registered as the output. One query is in flight at a time: the input
// stalls until its result enters the output; writes go one per cycle otherwise.
// Reset clears every pad to gate 0, mix 0, length 1 and empties the output.
// Depends on spcr_pkg and spcr_cell.
`timescale 1ns / 1ps

module step_pad_coverage_resolver #(
  parameter int StepCount = spcr_pkg::StepCountDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        in_kind_i,
  input  logic [spcr_pkg::StepW-1:0]  in_step_index_i,
  input  logic [spcr_pkg::GateW-1:0]  in_pad_gate_i,
  input  logic [spcr_pkg::MixW-1:0]   in_pad_mix_i,
  input  logic [spcr_pkg::LenW-1:0]   in_pad_length_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        out_covered_o,
  output logic [spcr_pkg::StepW-1:0]  out_start_step_o,
  output logic [spcr_pkg::StepW-1:0]  out_step_offset_o,
  output logic [spcr_pkg::LenW-1:0]   out_cover_length_o,
  output logic [spcr_pkg::MixW-1:0]   out_cover_mix_o
);
  import spcr_pkg::*;

  typedef enum logic [2:0] {
    StIdle   = 3'b001,
    StSearch = 3'b010,
    StWait   = 3'b100
  } state_e;

  state_e           state_d, state_q;
  logic             in_xfer;
  wr_t              wr;
  rec_t             launch;
  rec_t             chain [StepCount+1];
  rec_t             last;
  res_t             res_new;
  res_t             hold_d, hold_q;
  res_t             out_d, out_q;
  logic             out_vld_d, out_vld_q;
  logic             out_free;
  logic [StepW+1:0] reach;

  assign in_stall_o = (state_q != StIdle);
  assign in_xfer    = in_valid_i && !in_stall_o;

  // Broadcast writes to the row
  always_comb begin
    wr.en   = in_xfer && (in_kind_i == KindWrite);
    wr.step = in_step_index_i;
    wr.gate = in_pad_gate_i;
    wr.mix  = in_pad_mix_i;
    wr.len  = in_pad_length_i;
  end

  // Launch a query record into the first cell
  always_comb begin
    launch      = '0;
    launch.vld  = in_xfer && (in_kind_i == KindQuery);
    launch.step = in_step_index_i;
  end

  assign chain[0] = launch;

  for (genvar k = 0; k < StepCount; k++) begin : g_cell
    spcr_cell #(
      .CellIdx(k)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .wr_i  (wr),
      .rec_i (chain[k]),
      .rec_o (chain[k+1])
    );
  end

  assign last = chain[StepCount];

  // Resolve coverage from the nearest active pad
  assign reach = {2'b00, last.start} + {1'b0, last.len};

  always_comb begin
    res_new = '0;
    if (last.found && (int'(last.step) < StepCount) &&
        (reach > {2'b00, last.step})) begin
      res_new.covered = 1'b1;
      res_new.start   = last.start;
      res_new.offset  = last.step - last.start;
      res_new.len     = last.len;
      res_new.mix     = last.mix;
    end
  end

  assign out_free = !out_vld_q || !out_stall_i;

  // Sequence the search and hand results to the output register
  always_comb begin
    state_d   = state_q;
    hold_d    = hold_q;
    out_d     = out_q;
    out_vld_d = out_vld_q && out_stall_i;
    case (state_q)
      StIdle: begin
        if (launch.vld) begin
          state_d = StSearch;
        end
      end
      StSearch: begin
        if (last.vld) begin
          if (out_free) begin
            out_d     = res_new;
            out_vld_d = 1'b1;
            state_d   = StIdle;
          end else begin
            hold_d  = res_new;
            state_d = StWait;
          end
        end
      end
      StWait: begin
        if (out_free) begin
          out_d     = hold_q;
          out_vld_d = 1'b1;
          state_d   = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    hold_q <= hold_d;
    out_q  <= out_d;
  end

  assign out_valid_o        = out_vld_q;
  assign out_covered_o      = out_q.covered;
  assign out_start_step_o   = out_q.start;
  assign out_step_offset_o  = out_q.offset;
  assign out_cover_length_o = out_q.len;
  assign out_cover_mix_o    = out_q.mix;

endmodule

[sv/spcr_checker.sv]
// Port-level checks for the step pad coverage resolver, bound to the top level.
// Depends on spcr_pkg and step_pad_coverage_resolver.
`timescale 1ns / 1ps

module spcr_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic                        in_kind_i,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic                        out_covered_o,
  input logic [spcr_pkg::StepW-1:0]  out_start_step_o,
  input logic [spcr_pkg::StepW-1:0]  out_step_offset_o,
  input logic [spcr_pkg::LenW-1:0]   out_cover_length_o,
  input logic [spcr_pkg::MixW-1:0]   out_cover_mix_o
);
  import spcr_pkg::*;

  // A stalled result stays offered
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // An uncovered result carries all-zero fields
  a_uncovered_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_covered_o |->
      (out_start_step_o == '0) && (out_step_offset_o == '0) &&
      (out_cover_length_o == '0) && (out_cover_mix_o == '0))
    else $error("uncovered result with nonzero fields");

  // A covering pad reaches past the offset and has a nonzero mix
  a_covered_reach: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_covered_o |->
      ({1'b0, out_step_offset_o} < out_cover_length_o) && (out_cover_mix_o != '0))
    else $error("covering pad does not reach queried step");

  // A query transfer blocks input for the search
  a_query_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (in_kind_i == KindQuery) |=> in_stall_o)
    else $error("input open during search");

  // A write transfer leaves the input open
  a_write_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (in_kind_i == KindWrite) |=> !in_stall_o)
    else $error("input stalled after write");

endmodule

bind step_pad_coverage_resolver spcr_checker u_spcr_checker (.*);
